>>> rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned COUNT_BITS_DEFAULT = 28;
  localparam int unsigned LIMIT_W            = 28;
  localparam int unsigned QUEUE_DEPTH        = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(134217728);

  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_BYTES = 2'd1,
    STATUS_CHARS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_SKIP = 2'd0,
    KIND_PAD  = 2'd1,
    KIND_DATA = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [5:0] sextet;
    logic       last;
    logic       enc_over;
  } entry_t;

endpackage

>>> rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Classifies each character and counts characters against the encoded limit.
// ----------------------------------------------------------------------------
module b64d_front #(
  parameter int unsigned COUNT_BITS = b64d_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [b64d_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic [7:0]                    symbol_i,
  input  logic                          message_end_i,
  input  logic                          full_i,
  output logic                          push_o,
  output b64d_pkg::entry_t              entry_o
);

  localparam int unsigned ENC_W = b64d_pkg::LIMIT_W + 3;
  localparam int unsigned CMP_W = (COUNT_BITS + 2 > ENC_W) ? COUNT_BITS + 2 : ENC_W;
  localparam logic [ENC_W-1:0] ENC_RESET =
    {b64d_pkg::LIMIT_RESET, 2'b00} + ENC_W'(12);

  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_next;
  logic [ENC_W-1:0]      enc_lim_q;
  logic [CMP_W-1:0]      cnt_x3;
  logic [5:0]            sextet;
  logic                  is_alpha;

  // 4L+12 is kept so the check 3*count > 4L+12 matches count > floor(4L/3)+4
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_lim_q <= ENC_RESET;
    end else if (cfg_we_i) begin
      enc_lim_q <= {cfg_wdata_i, 2'b00} + ENC_W'(12);
    end
  end

  always_comb begin
    sextet   = 6'd0;
    is_alpha = 1'b1;
    if (symbol_i >= 8'h41 && symbol_i <= 8'h5A) begin
      sextet = 6'(symbol_i - 8'h41);
    end else if (symbol_i >= 8'h61 && symbol_i <= 8'h7A) begin
      sextet = 6'(symbol_i - 8'h47);
    end else if (symbol_i >= 8'h30 && symbol_i <= 8'h39) begin
      sextet = 6'(symbol_i + 8'h04);
    end else if (symbol_i == 8'h2B) begin
      sextet = b64d_pkg::SEXTET_PLUS;
    end else if (symbol_i == 8'h2F) begin
      sextet = b64d_pkg::SEXTET_SLASH;
    end else begin
      is_alpha = 1'b0;
    end
  end

  always_comb begin
    cnt_next = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_BITS'(1);
    cnt_x3   = CMP_W'(cnt_next) + (CMP_W'(cnt_next) << 1);
    push_o   = in_valid_i && !full_i;

    entry_o.sextet   = sextet;
    entry_o.last     = message_end_i;
    entry_o.enc_over = cnt_x3 > CMP_W'(enc_lim_q);
    if (symbol_i == b64d_pkg::CHAR_PAD) begin
      entry_o.kind = b64d_pkg::KIND_PAD;
    end else if (is_alpha) begin
      entry_o.kind = b64d_pkg::KIND_DATA;
    end else begin
      entry_o.kind = b64d_pkg::KIND_SKIP;
    end

    cnt_d = cnt_q;
    if (push_o) begin
      cnt_d = message_end_i ? '0 : cnt_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short FIFO of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module b64d_queue #(
  parameter int unsigned DEPTH = b64d_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  b64d_pkg::entry_t entry_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             head_valid_o,
  output b64d_pkg::entry_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  b64d_pkg::entry_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o       = cnt_q == CNT_W'(DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Bit accumulator, byte limit check and registered result word.
// ----------------------------------------------------------------------------
module b64d_back #(
  parameter int unsigned COUNT_BITS = b64d_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [b64d_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  logic                          head_valid_i,
  input  b64d_pkg::entry_t              head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    data_byte_o,
  output logic                          byte_valid_o,
  output logic                          last_o,
  output logic [1:0]                    status_o
);

  localparam int unsigned BC_W =
    (COUNT_BITS > b64d_pkg::LIMIT_W) ? COUNT_BITS : b64d_pkg::LIMIT_W;

  logic [b64d_pkg::LIMIT_W-1:0] limit_q;
  logic [11:0]           acc_q, acc_d;
  logic [3:0]            pend_q, pend_d, pend_sum;
  logic                  pad_q, pad_d;
  logic [COUNT_BITS-1:0] bc_q, bc_d;
  b64d_pkg::status_e     err_q, err_d;

  logic                  go, emit;
  logic [7:0]            dec_byte;

  logic                  out_valid_q, out_valid_d;
  logic [7:0]            data_q;
  logic                  bvalid_q, last_q;
  b64d_pkg::status_e     status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= b64d_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    go       = head_valid_i && (!out_valid_q || !out_stall_i);
    pop_o    = go;
    acc_d    = acc_q;
    pend_d   = pend_q;
    pad_d    = pad_q;
    bc_d     = bc_q;
    err_d    = head_i.enc_over ? b64d_pkg::STATUS_CHARS : err_q;
    emit     = 1'b0;
    dec_byte = 8'd0;
    pend_sum = pend_q + 4'd6;

    if (err_d == b64d_pkg::STATUS_OK && !pad_q) begin
      case (head_i.kind)
        b64d_pkg::KIND_PAD: begin
          pad_d = 1'b1;
        end
        b64d_pkg::KIND_DATA: begin
          acc_d  = {acc_q[5:0], head_i.sextet};
          pend_d = pend_sum;
          if (pend_sum >= 4'd8) begin
            pend_d = pend_sum - 4'd8;
            if (BC_W'(bc_q) >= BC_W'(limit_q)) begin
              err_d = b64d_pkg::STATUS_BYTES;
            end else begin
              bc_d     = (bc_q == '1) ? bc_q : bc_q + COUNT_BITS'(1);
              emit     = 1'b1;
              dec_byte = 8'(acc_d >> (pend_sum - 4'd8));
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (head_i.last) begin
      acc_d  = '0;
      pend_d = '0;
      pad_d  = 1'b0;
      bc_d   = '0;
      err_d  = b64d_pkg::STATUS_OK;
    end

    out_valid_d = out_valid_q;
    if (go) begin
      out_valid_d = emit || head_i.last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pend_q      <= '0;
      pad_q       <= 1'b0;
      bc_q        <= '0;
      err_q       <= b64d_pkg::STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (go) begin
        acc_q  <= acc_d;
        pend_q <= pend_d;
        pad_q  <= pad_d;
        bc_q   <= bc_d;
        err_q  <= err_d;
      end
    end
  end

  // status reported is the code after this word's update, before clearing
  always_ff @(posedge clk_i) begin
    if (go && (emit || head_i.last)) begin
      data_q   <= dec_byte;
      bvalid_q <= emit;
      last_q   <= head_i.last;
      if (!head_i.last) begin
        status_q <= b64d_pkg::STATUS_OK;
      end else if (head_i.enc_over) begin
        status_q <= b64d_pkg::STATUS_CHARS;
      end else if (err_q != b64d_pkg::STATUS_OK) begin
        status_q <= err_q;
      end else if (head_i.kind == b64d_pkg::KIND_DATA && !pad_q && pend_sum >= 4'd8 &&
                   BC_W'(bc_q) >= BC_W'(limit_q)) begin
        status_q <= b64d_pkg::STATUS_BYTES;
      end else begin
        status_q <= b64d_pkg::STATUS_OK;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_byte_o  = data_q;
  assign byte_valid_o = bvalid_q;
  assign last_o       = last_q;
  assign status_o     = status_q;

endmodule

>>> rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder with per-message character and byte limits.
// ----------------------------------------------------------------------------
// One character is accepted per cycle, sustained; the queue entry and the
// back-end output register lie between a character and its result word.
// The back end updates accumulator and limits and takes one queued word
// per cycle while its output is not held stalled. The input stalls only
// when the two-entry queue is full, which happens while the output is held
// stalled. Bytes beyond byte_limit are dropped and the error is reported
// in status on the last word of the message; all message state then clears.
module base64_stream_decoder #(
  parameter int unsigned COUNT_BITS = b64d_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [b64d_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    symbol_i,
  input  logic                          message_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    data_byte_o,
  output logic                          byte_valid_o,
  output logic                          last_o,
  output logic [1:0]                    status_o
);

  logic             push, pop, full, head_valid;
  b64d_pkg::entry_t entry, head;

  assign in_stall_o = full;

  b64d_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .symbol_i      (symbol_i),
    .message_end_i (message_end_i),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (entry)
  );

  b64d_queue #(
    .DEPTH (b64d_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  b64d_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_byte_o  (data_byte_o),
    .byte_valid_o (byte_valid_o),
    .last_o       (last_o),
    .status_o     (status_o)
  );

endmodule

>>> rtl/b64d_checker.sv
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks for the base64 stream decoder.
// ----------------------------------------------------------------------------
module b64d_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [7:0]                    symbol_i,
  input logic                          message_end_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [7:0]                    data_byte_o,
  input logic                          byte_valid_o,
  input logic                          last_o,
  input logic [1:0]                    status_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(symbol_i) &&
    $stable(message_end_i))
    else $error("input word changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_byte_o) &&
    $stable(byte_valid_o) && $stable(last_o) && $stable(status_o))
    else $error("result word changed while stalled");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == b64d_pkg::STATUS_OK)
    else $error("error status on a word that is not last");

  a_word_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_valid_o || last_o)
    else $error("result word carries neither byte nor end");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= b64d_pkg::STATUS_CHARS)
    else $error("undefined status code");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);

>>> dv/base64_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_tb
// Self-checking bench for the streaming base64 decoder. Character words are
// queued by a stimulus process and driven on falling edges; outside the calm
// phase there are random gaps and random output stalls. Each accepted
// character updates a local decoder model that queues the result words it
// should cause. Result words are checked field by field against that queue.
// ----------------------------------------------------------------------------
module base64_stream_decoder_tb;

  localparam int MAX_CYCLES = 200000;
  localparam longint unsigned CNT_MAX = (64'd1 << b64d_pkg::COUNT_BITS_DEFAULT) - 1;

  typedef struct packed {
    logic [7:0] symbol;
    logic       msg_end;
  } char_t;

  typedef struct packed {
    logic [7:0]        data;
    logic              valid;
    logic              last;
    b64d_pkg::status_e status;
  } result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [b64d_pkg::LIMIT_W-1:0] cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [7:0]                   symbol_i;
  logic                         message_end_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [7:0]                   data_byte_o;
  logic                         byte_valid_o;
  logic                         last_o;
  logic [1:0]                   status_o;

  base64_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .symbol_i      (symbol_i),
    .message_end_i (message_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_byte_o   (data_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_o        (last_o),
    .status_o      (status_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // decoder model state
  logic [b64d_pkg::LIMIT_W-1:0] byte_lim;
  logic [11:0]                  acc;
  int                           nbits;
  logic                         pad_seen;
  longint unsigned              char_cnt;
  longint unsigned              byte_cnt;
  b64d_pkg::status_e            err;

  char_t   char_q[$];
  result_t expected_words[$];
  char_t   next_char;
  result_t want, got;
  logic    in_took;
  logic    calm;
  int      queued_cnt;
  int      taken_cnt;
  int      n_bad;
  int      cycles;

  function automatic int b64_value(logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c - "A");
    if (c >= "a" && c <= "z") return int'(c - "a") + 26;
    if (c >= "0" && c <= "9") return int'(c - "0") + 52;
    if (c == "+") return int'(b64d_pkg::SEXTET_PLUS);
    if (c == "/") return int'(b64d_pkg::SEXTET_SLASH);
    return -1;
  endfunction

  function automatic logic [7:0] b64_char(logic [5:0] s);
    if (s < 26) return 8'("A" + s);
    if (s < 52) return 8'("a" + s - 26);
    if (s < b64d_pkg::SEXTET_PLUS) return 8'("0" + s - 52);
    if (s == b64d_pkg::SEXTET_PLUS) return "+";
    return "/";
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(2))
      0: return 8'h20;
      1: return 8'(9 + $urandom_range(4));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic clear_message();
    acc = '0;
    nbits = 0;
    pad_seen = 1'b0;
    char_cnt = 0;
    byte_cnt = 0;
    err = b64d_pkg::STATUS_OK;
  endtask

  task automatic decode_char(input logic [7:0] c, input logic fin);
    longint unsigned enc_lim;
    result_t r;
    int v;
    r = '{data: 8'h00, valid: 1'b0, last: 1'b0, status: b64d_pkg::STATUS_OK};
    enc_lim = (longint'(byte_lim) * 4) / 3 + 4;
    if (char_cnt < CNT_MAX) char_cnt++;
    if (char_cnt > enc_lim) err = b64d_pkg::STATUS_CHARS;
    if (err == b64d_pkg::STATUS_OK && !pad_seen && !is_blank(c)) begin
      if (c == b64d_pkg::CHAR_PAD) begin
        pad_seen = 1'b1;
      end else begin
        v = b64_value(c);
        if (v >= 0) begin
          acc = {acc[5:0], 6'(v)};
          nbits += 6;
          if (nbits >= 8) begin
            nbits -= 8;
            if (byte_cnt >= longint'(byte_lim)) begin
              err = b64d_pkg::STATUS_BYTES;
            end else begin
              byte_cnt++;
              r.data = 8'(acc >> nbits);
              r.valid = 1'b1;
            end
          end
        end
      end
    end
    if (r.valid || fin) begin
      r.last = fin;
      r.status = fin ? err : b64d_pkg::STATUS_OK;
      expected_words.insert(expected_words.size(), r);
    end
    if (fin) clear_message();
  endtask

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (char_q.size() != 0 && (calm || $urandom_range(99) >= 27)) begin
        next_char = char_q.pop_front();
        in_valid_i <= 1'b1;
        symbol_i <= next_char.symbol;
        message_end_i <= next_char.msg_end;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= !calm && $urandom_range(99) < 27;
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      in_took <= rst_ni && in_valid_i && !in_stall_o;
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = '{data: data_byte_o, valid: byte_valid_o, last: last_o,
                status: b64d_pkg::status_e'(status_o)};
        if (expected_words.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected word: data=%h valid=%b last=%b status=%0d",
                     got.data, got.valid, got.last, got.status);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch: exp %h/%b/%b/%0d got %h/%b/%b/%0d",
                       want.data, want.valid, want.last, want.status,
                       got.data, got.valid, got.last, got.status);
          end
        end
      end
      if (rst_ni && in_valid_i && !in_stall_o) begin
        decode_char(symbol_i, message_end_i);
        taken_cnt++;
      end
    end
  end

  task automatic push_char(logic [7:0] c, logic fin);
    char_q.insert(char_q.size(), char_t'{symbol: c, msg_end: fin});
    queued_cnt++;
  endtask

  task automatic push_text(string s, logic fin);
    for (int i = 0; i < s.len(); i++) push_char(s[i], fin && i == s.len() - 1);
  endtask

  task automatic push_encoded(int nbytes, bit pad, bit noisy);
    logic [7:0] raw[$];
    logic [7:0] txt[$];
    logic [7:0] b0, b1, b2;
    int n;
    for (int i = 0; i < nbytes; i++) raw.insert(raw.size(), 8'($urandom));
    for (int i = 0; i < nbytes; i += 3) begin
      n = nbytes - i;
      b0 = raw[i];
      b1 = (n > 1) ? raw[i+1] : 8'h00;
      b2 = (n > 2) ? raw[i+2] : 8'h00;
      txt.insert(txt.size(), b64_char(b0[7:2]));
      txt.insert(txt.size(), b64_char({b0[1:0], b1[7:4]}));
      if (n > 1) txt.insert(txt.size(), b64_char({b1[3:0], b2[7:6]}));
      else if (pad) txt.insert(txt.size(), b64d_pkg::CHAR_PAD);
      if (n > 2) txt.insert(txt.size(), b64_char(b2[5:0]));
      else if (pad) txt.insert(txt.size(), b64d_pkg::CHAR_PAD);
    end
    if (txt.size() == 0) txt.insert(0, 8'h20);
    for (int i = 0; i < txt.size(); i++) begin
      if (noisy && $urandom_range(7) == 0) push_char(noise_char(), 1'b0);
      push_char(txt[i], i == txt.size() - 1);
    end
  endtask

  task automatic wait_idle();
    while (taken_cnt != queued_cnt || expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [b64d_pkg::LIMIT_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    byte_lim = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int target;
    int len;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    symbol_i = 8'h00;
    message_end_i = 1'b0;
    out_stall_i = 1'b0;
    in_took = 1'b0;
    calm = 1'b0;
    queued_cnt = 0;
    taken_cnt = 0;
    n_bad = 0;
    cycles = 0;
    byte_lim = b64d_pkg::LIMIT_RESET;
    clear_message();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset limit: alphabet edges, blanks, skipped bytes, padding, leftover bits
    push_text("TW\tFu+/9z", 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(8'h00, 1'b0);
    push_char(8'h0B, 1'b0);
    push_char(8'h0C, 1'b0);
    push_char(8'h0D, 1'b0);
    push_char(8'h0A, 1'b0);
    push_char(8'h08, 1'b0);
    push_char(8'h0E, 1'b0);
    push_text("QQ==QUJD", 1'b1);
    push_text(" ", 1'b1);
    wait_idle();

    // zero limit: first byte is an overflow
    set_limit('0);
    push_text("QUJD", 1'b1);
    wait_idle();

    // limit of one: byte overflow, then the char limit takes over
    set_limit(28'd1);
    push_text("QUJD   ", 1'b1);
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_limit(b64d_pkg::LIMIT_RESET);
        1: set_limit(28'($urandom_range(24, 2)));
        2: set_limit(28'd1);
        3: set_limit(28'($urandom_range(b64d_pkg::LIMIT_RESET - 1)));
        4: set_limit(28'($urandom_range(60, 25)));
        default: set_limit(28'($urandom_range(12, 2)));
      endcase
      calm = (phase == 3);
      target = queued_cnt + 280;
      while (queued_cnt < target) begin
        case ($urandom_range(99) / 10)
          8: begin
            len = $urandom_range(20, 1);
            for (int i = 0; i < len; i++) begin
              if ($urandom_range(1) == 0)
                push_char(8'($urandom_range(255)), i == len - 1);
              else
                push_char(b64_char(6'($urandom)), i == len - 1);
            end
          end
          9: begin
            len = $urandom_range(4);
            for (int i = 0; i < len; i++) push_char(noise_char(), 1'b0);
            push_char(($urandom_range(1) == 0) ? b64d_pkg::CHAR_PAD : noise_char(), 1'b1);
          end
          default: begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(30);
            push_encoded(len, $urandom_range(3) != 0, $urandom_range(3) == 0);
          end
        endcase
      end
      wait_idle();
    end
    calm = 1'b0;

    if (n_bad == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_stream_decoder.sv
rtl/b64d_checker.sv
dv/base64_stream_decoder_tb.sv
